>>> rtl/swm_pkg.sv
// Shared types and constants for the sliding window median unit.
// No dependencies; imported by every other file of the block.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int WS_W     = 7;

  // APB register map: one 32-bit register per word
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;
  localparam logic [WS_W-1:0]      WS_RESET        = 7'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;

  // per-cycle command broadcast to every window cell
  typedef struct packed {
    logic shift;  // new sample enters, all samples age by one cell
    logic load;   // copy own sample into the token slot, clear rank
    logic step;   // compare against token, pass token to the neighbor
  } cell_ctrl_t;

endpackage

>>> rtl/swm_ifs.sv
// Valid/ready channel interfaces for sample input and median output.
// Depends on swm_pkg.
interface swm_in_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic    valid;
  logic    ready;
  median_t median_twice;

  modport source (output valid, output median_twice, input ready);
  modport sink   (input valid, input median_twice, output ready);
endinterface

>>> rtl/swm_cfg.sv
// APB configuration register block: holds window_size.
// Depends on swm_pkg.
module swm_cfg import swm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WS_W-1:0]       window_size
);

  logic                 hit;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign hit     = (reg_idx == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      window_size <= pwdata[WS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(CFG_DATA_W-WS_W){1'b0}}, window_size};
    end
  end

endmodule

>>> rtl/swm_cell.sv
// One window cell: holds a sample at a fixed age, ranks it against a token
// that travels down the chain, and offers its sample when its rank is picked.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int POS   = 0
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] k,
  input  logic [IDX_W-1:0] sel_lo,
  input  logic [IDX_W-1:0] sel_hi,
  input  sample_t          prev_val,
  input  sample_t          tok_in_val,
  input  logic [IDX_W-1:0] tok_in_idx,
  output sample_t          val,
  output sample_t          tok_val,
  output logic [IDX_W-1:0] tok_idx,
  output sample_t          lo_val,
  output sample_t          hi_val
);

  logic [IDX_W-1:0] rank;
  logic             less;
  logic             active;

  // ties broken by age so ranks in the window are a permutation
  assign less   = (tok_val < val) || ((tok_val == val) && (tok_idx < IDX_W'(POS)));
  assign active = (CNT_W'(POS) < k);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      val <= prev_val;
    end
    if (ctrl.load) begin
      tok_val <= val;
      tok_idx <= IDX_W'(POS);
      rank    <= '0;
    end else if (ctrl.step) begin
      rank    <= rank + IDX_W'(less);
      tok_val <= tok_in_val;
      tok_idx <= tok_in_idx;
    end
  end

  assign lo_val = (active && rank == sel_lo) ? val : '0;
  assign hi_val = (active && rank == sel_hi) ? val : '0;

endmodule

>>> rtl/sliding_window_median_unit.sv
// Running median filter over signed 32-bit samples. Samples shift into a chain
// of WINDOW_MAX cells ordered by age; once window_size samples are held since
// reset or the last restart, each sample yields twice the median of the newest
// window_size samples (sum of the two middle values for an even size). A
// sample that does not complete the window gives no result. A sample that
// gives a result goes through these steps in order: accept, load the tokens,
// window_size steps while each sample circulates once around the window
// cells for ranking, pick the middle pair, and add the pair into the output
// register once that register is free. Ready is high only between samples.
// window_size is read at acceptance; 0 acts as 1, values above WINDOW_MAX as
// WINDOW_MAX. Depends on swm_pkg, swm_ifs, swm_cfg and swm_cell.
module sliding_window_median_unit import swm_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  swm_in_if.sink                samples,
  swm_out_if.source             medians
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;

  logic [WS_W-1:0]  window_size;
  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] k;
  logic [IDX_W-1:0] k_m1;
  logic [IDX_W-1:0] step_cnt;
  logic [IDX_W-1:0] sel_lo;
  logic [IDX_W-1:0] sel_hi;
  logic [CNT_W-1:0] half;
  logic             in_acc;
  logic             out_free;
  cell_ctrl_t       ctrl;
  sample_t          lo;
  sample_t          hi;
  sample_t          lo_or;
  sample_t          hi_or;
  median_t          out_data;
  logic             out_valid;

  sample_t          val     [WINDOW_MAX];
  sample_t          tok_val [WINDOW_MAX];
  logic [IDX_W-1:0] tok_idx [WINDOW_MAX];
  sample_t          lo_val  [WINDOW_MAX];
  sample_t          hi_val  [WINDOW_MAX];

  swm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  assign samples.ready = (state == S_IDLE);
  assign in_acc        = samples.valid && samples.ready;
  assign out_free      = !out_valid || medians.ready;

  always_comb begin
    if (window_size == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      k_eff = CNT_W'(WINDOW_MAX);
    end else begin
      k_eff = CNT_W'(window_size);
    end
  end

  always_comb begin
    if (samples.restart) begin
      fill_next = CNT_W'(1);
    end else if (fill < CNT_W'(WINDOW_MAX)) begin
      fill_next = fill + CNT_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  // middle pair ranks; equal for an odd size
  assign half   = k >> 1;
  assign sel_hi = IDX_W'(half);
  assign sel_lo = k[0] ? sel_hi : sel_hi - IDX_W'(1);

  always_comb begin
    ctrl.shift = in_acc;
    ctrl.load  = (state == S_PRIME);
    ctrl.step  = (state == S_COUNT);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && fill_next >= k_eff) begin
          state_next = S_PRIME;
        end
      end
      S_PRIME: state_next = S_COUNT;
      S_COUNT: begin
        if (step_cnt == k_m1) begin
          state_next = S_PICK;
        end
      end
      S_PICK: state_next = S_SUM;
      S_SUM: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fill <= fill_next;
      end
      if (state == S_SUM && out_free) begin
        out_valid <= 1'b1;
      end else if (medians.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      k    <= k_eff;
      k_m1 <= IDX_W'(k_eff - CNT_W'(1));
    end
    if (state == S_PRIME) begin
      step_cnt <= '0;
    end else if (state == S_COUNT) begin
      step_cnt <= step_cnt + IDX_W'(1);
    end
    if (state == S_PICK) begin
      lo <= lo_or;
      hi <= hi_or;
    end
    if (state == S_SUM && out_free) begin
      out_data <= {lo[SAMPLE_W-1], lo} + {hi[SAMPLE_W-1], hi};
    end
  end

  assign medians.valid        = out_valid;
  assign medians.median_twice = out_data;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
      sample_t          prev_v;
      sample_t          tin_v;
      logic [IDX_W-1:0] tin_i;

      if (gi == 0) begin : g_head
        // token ring closes at the last cell inside the window
        assign prev_v = samples.sample;
        assign tin_v  = tok_val[k_m1];
        assign tin_i  = tok_idx[k_m1];
      end else begin : g_body
        assign prev_v = val[gi-1];
        assign tin_v  = tok_val[gi-1];
        assign tin_i  = tok_idx[gi-1];
      end

      swm_cell #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W),
        .POS   (gi)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .k          (k),
        .sel_lo     (sel_lo),
        .sel_hi     (sel_hi),
        .prev_val   (prev_v),
        .tok_in_val (tin_v),
        .tok_in_idx (tin_i),
        .val        (val[gi]),
        .tok_val    (tok_val[gi]),
        .tok_idx    (tok_idx[gi]),
        .lo_val     (lo_val[gi]),
        .hi_val     (hi_val[gi])
      );
    end
  endgenerate

  // exactly one window cell matches each selected rank
  always_comb begin
    lo_or = '0;
    hi_or = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      lo_or = lo_or | lo_val[i];
      hi_or = hi_or | hi_val[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_COUNT |-> step_cnt <= k_m1)
    else $error("ranking step count ran past the window");

  a_prime_full: assert property (@(posedge clk) disable iff (rst)
    state == S_PRIME |-> fill >= k)
    else $error("ranking started before the window was full");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SUM |-> lo <= hi)
    else $error("middle pair out of order");

  a_restart_fill: assert property (@(posedge clk) disable iff (rst)
    in_acc && samples.restart |=> fill == CNT_W'(1))
    else $error("restart did not reset the fill count");

endmodule
